[rtl/cpt_pkg.sv]
// Shared types and constants for the closest-point-on-triangle pipeline.
// No dependencies; imported by the interfaces and every module but cpt_dly.
package cpt_pkg;

	// fractional bits of a ratio; 2**FRAC_BITS stands for one
	localparam int FRAC_BITS = 64;

	// multiplier slicing: operand chunk width and latency in cycles
	localparam int MUL_CHUNK = 32;
	localparam int MUL_LAT   = 3;

	// divider: one flag stage plus one stage per quotient bit
	localparam int DIV_LAT = FRAC_BITS + 1;

	// Voronoi region of the query point
	typedef enum logic [2:0] {
		REG_VTX_A   = 3'd0,
		REG_VTX_B   = 3'd1,
		REG_EDGE_AB = 3'd2,
		REG_VTX_C   = 3'd3,
		REG_EDGE_AC = 3'd4,
		REG_EDGE_BC = 3'd5,
		REG_FACE    = 3'd6
	} region_t;

endpackage

[rtl/cpt_query_if.sv]
// Query channel: valid/ready handshake carrying the query point and triangle corners.
// Depends on cpt_pkg.
interface cpt_query_if
	import cpt_pkg::*;
#(
	parameter int COORD_BITS = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] query_x;
	logic signed [COORD_BITS-1:0] query_y;
	logic signed [COORD_BITS-1:0] query_z;
	logic signed [COORD_BITS-1:0] corner_a_x;
	logic signed [COORD_BITS-1:0] corner_a_y;
	logic signed [COORD_BITS-1:0] corner_a_z;
	logic signed [COORD_BITS-1:0] corner_b_x;
	logic signed [COORD_BITS-1:0] corner_b_y;
	logic signed [COORD_BITS-1:0] corner_b_z;
	logic signed [COORD_BITS-1:0] corner_c_x;
	logic signed [COORD_BITS-1:0] corner_c_y;
	logic signed [COORD_BITS-1:0] corner_c_z;

	modport source (
		output valid, query_x, query_y, query_z,
		output corner_a_x, corner_a_y, corner_a_z,
		output corner_b_x, corner_b_y, corner_b_z,
		output corner_c_x, corner_c_y, corner_c_z,
		input  ready
	);

	modport sink (
		input  valid, query_x, query_y, query_z,
		input  corner_a_x, corner_a_y, corner_a_z,
		input  corner_b_x, corner_b_y, corner_b_z,
		input  corner_c_x, corner_c_y, corner_c_z,
		output ready
	);
endinterface

[rtl/cpt_result_if.sv]
// Result channel: valid/ready handshake carrying the nearest point and its region.
// Depends on cpt_pkg (region_t).
interface cpt_result_if
	import cpt_pkg::*;
#(
	parameter int COORD_BITS = 32
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] nearest_x;
	logic signed [COORD_BITS-1:0] nearest_y;
	logic signed [COORD_BITS-1:0] nearest_z;
	region_t                      region;

	modport source (
		output valid, nearest_x, nearest_y, nearest_z, region,
		input  ready
	);

	modport sink (
		input  valid, nearest_x, nearest_y, nearest_z, region,
		output ready
	);
endinterface

[rtl/cpt_dly.sv]
// Enabled shift register that carries side data alongside the pipeline.
// Depends on nothing but its parameters.
module cpt_dly #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);
	logic [WIDTH-1:0] sr_q [DEPTH];

	// shift one place per advancing cycle
	always_ff @(posedge clk) begin
		if (en) begin
			sr_q[0] <= d;
			for (int i = 1; i < DEPTH; i++) begin
				sr_q[i] <= sr_q[i-1];
			end
		end
	end

	assign q = sr_q[DEPTH-1];
endmodule

[rtl/cpt_mul.sv]
// Pipelined signed multiplier built from chunk-sized partial products.
// Depends on cpt_pkg (MUL_CHUNK).
module cpt_mul
	import cpt_pkg::*;
#(
	parameter int AW = 33,
	parameter int BW = 33
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [AW-1:0]    a,
	input  logic signed [BW-1:0]    b,
	output logic signed [AW+BW-1:0] p
);
	localparam int PW  = AW + BW;
	localparam int NA  = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int NB  = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int XA  = NA * MUL_CHUNK;
	localparam int XB  = NB * MUL_CHUNK;
	localparam int PPW = 2 * MUL_CHUNK + 2;

	logic signed [XA-1:0]        ax;
	logic signed [XB-1:0]        bx;
	logic signed [MUL_CHUNK:0]   ach [NA];
	logic signed [MUL_CHUNK:0]   bch [NB];
	logic signed [PPW-1:0]       pp_q [NA][NB];
	logic signed [PW-1:0]        row_c [NA];
	logic signed [PW-1:0]        row_q [NA];
	logic signed [PW-1:0]        sum_c;

	assign ax = XA'(a);
	assign bx = XB'(b);

	// low chunks unsigned, top chunk carries the sign
	for (genvar i = 0; i < NA; i++) begin : g_achunk
		if (i == NA - 1) begin : g_top
			assign ach[i] = {ax[XA-1], ax[i*MUL_CHUNK +: MUL_CHUNK]};
		end else begin : g_low
			assign ach[i] = {1'b0, ax[i*MUL_CHUNK +: MUL_CHUNK]};
		end
	end
	for (genvar j = 0; j < NB; j++) begin : g_bchunk
		if (j == NB - 1) begin : g_top
			assign bch[j] = {bx[XB-1], bx[j*MUL_CHUNK +: MUL_CHUNK]};
		end else begin : g_low
			assign bch[j] = {1'b0, bx[j*MUL_CHUNK +: MUL_CHUNK]};
		end
	end

	// stage 1: partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_q[i][j] <= ach[i] * bch[j];
				end
			end
		end
	end

	// stage 2: one row per chunk of a
	always_comb begin
		for (int i = 0; i < NA; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < NB; j++) begin
				row_c[i] = row_c[i] + (PW'(pp_q[i][j]) <<< (j * MUL_CHUNK));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			row_q <= row_c;
		end
	end

	// stage 3: rows together
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NA; i++) begin
			sum_c = sum_c + (row_q[i] <<< (i * MUL_CHUNK));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p <= sum_c;
		end
	end
endmodule

[rtl/cpt_div.sv]
// Pipelined ratio unit: floor(num * 2**FRAC_BITS / den), clamped to 0..1.
// One flag stage, then one restoring step per quotient bit. Depends on cpt_pkg.
module cpt_div
	import cpt_pkg::*;
#(
	parameter int NW = 139
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [NW-1:0] num,
	input  logic signed [NW-1:0] den,
	output logic [FRAC_BITS:0]   ratio
);
	localparam int RMW = NW - 1;

	logic [RMW-1:0]       rem_q  [FRAC_BITS+1];
	logic [RMW-1:0]       dvs_q  [FRAC_BITS+1];
	logic [FRAC_BITS-1:0] quo_q  [FRAC_BITS+1];
	logic                 zero_q [FRAC_BITS+1];
	logic                 one_q  [FRAC_BITS+1];

	// flag stage: nonpositive terms give 0, num at or above den gives 1
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= num[RMW-1:0];
			dvs_q[0]  <= den[RMW-1:0];
			quo_q[0]  <= '0;
			zero_q[0] <= (den <= 0) || (num <= 0);
			one_q[0]  <= (den <= num);
		end
	end

	// one quotient bit per stage; remainder stays below the divisor
	for (genvar g = 0; g < FRAC_BITS; g++) begin : g_step
		logic [NW-1:0] sh;
		logic [NW-1:0] dif;
		logic          ge;

		always_comb begin
			sh  = {rem_q[g], 1'b0};
			dif = sh - {1'b0, dvs_q[g]};
			ge  = (sh >= {1'b0, dvs_q[g]});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[g+1]  <= ge ? dif[RMW-1:0] : sh[RMW-1:0];
				dvs_q[g+1]  <= dvs_q[g];
				quo_q[g+1]  <= {quo_q[g][FRAC_BITS-2:0], ge};
				zero_q[g+1] <= zero_q[g];
				one_q[g+1]  <= one_q[g];
			end
		end
	end

	assign ratio = zero_q[FRAC_BITS] ? '0 :
		one_q[FRAC_BITS] ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, quo_q[FRAC_BITS]};
endmodule

[rtl/closest_point_on_triangle_top.sv]
// Top level of the closest-point-on-triangle pipeline.
// Depends on cpt_pkg, cpt_query_if, cpt_result_if, cpt_mul, cpt_div, cpt_dly.
//
// Usage:
//  query  - sink channel; one word holds the query point and corners a, b, c,
//           all signed Q16.16 of COORD_BITS bits.
//  result - source channel; one word per query holds the nearest point on the
//           triangle (saturated Q16.16) and its Voronoi region code.
//  Throughput: one word per cycle in both directions while not stalled.
//  Depth: the two ratio dividers, each a flag stage and 64 restoring steps,
//    make up most of the pipeline.
//  Stages: difference vectors, sliced dot products, sliced cross terms,
//    region select, two ratio dividers, scaled edge terms, sum and saturate.
//  Reset: arst_n clears all valid bits; nothing is in flight after reset and
//    no clearing pass is needed.
//  Stall: while the output word waits and result.ready is low, the whole
//    pipeline holds and query.ready is low; nothing is lost or repeated.
module closest_point_on_triangle_top
	import cpt_pkg::*;
#(
	parameter int COORD_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	cpt_query_if.sink     query,
	cpt_result_if.source  result
);
	localparam int W       = COORD_BITS;
	localparam int DW      = W + 1;
	localparam int DOTW    = 2 * W + 4;
	localparam int EW      = DOTW + 1;
	localparam int XW      = 2 * DOTW + 1;
	localparam int NW      = XW + 2;
	localparam int RW      = FRAC_BITS + 1;
	localparam int SW      = RW + 1 + DW;
	localparam int TW      = SW - FRAC_BITS;
	localparam int SUMW    = TW + 2;
	localparam int CRN_DLY = 2 * MUL_LAT + 3;
	localparam int LAT     = CRN_DLY + 1 + DIV_LAT + MUL_LAT + 1;
	localparam int RAT_STG = CRN_DLY + 1 + DIV_LAT;

	// cross term operand pairs: vc = d1*d4 - d3*d2, vb = d5*d2 - d1*d6,
	// va = d3*d6 - d5*d4
	localparam int XL [6] = '{0, 2, 4, 0, 2, 4};
	localparam int XR [6] = '{3, 1, 1, 5, 5, 3};

	logic             en;
	logic [LAT-1:0]   vld_q;

	logic signed [W-1:0]      pin [3];
	logic signed [W-1:0]      cin [3][3];
	logic [9*W-1:0]           crn_in;
	logic [9*W-1:0]           crn_d;
	logic signed [W-1:0]      crn_s9 [3][3];

	logic signed [DW-1:0]     u_s1 [2][3];
	logic signed [DW-1:0]     v_s1 [3][3];
	logic signed [2*DW-1:0]   dp_s4 [6][3];
	logic signed [DOTW-1:0]   dot_s5 [6];
	logic [6*DOTW-1:0]        dot_pk;
	logic [6*DOTW-1:0]        dot_d;
	logic signed [DOTW-1:0]   dot_s8 [6];
	logic signed [2*DOTW-1:0] xp_s8 [6];
	logic signed [DOTW-1:0]   dot_s9 [6];
	logic signed [XW-1:0]     cr_s9 [3];
	logic signed [EW-1:0]     t_s9;
	logic signed [EW-1:0]     u_s9;

	region_t                  reg_c;
	logic signed [NW-1:0]     num1_c, num2_c, den_c;
	logic signed [W-1:0]      base_c [3];
	logic signed [DW-1:0]     dir1_c [3];
	logic signed [DW-1:0]     dir2_c [3];

	region_t                  reg_s10;
	logic signed [NW-1:0]     num1_s10, num2_s10, den_s10;
	logic signed [W-1:0]      base_s10 [3];
	logic signed [DW-1:0]     dir1_s10 [3];
	logic signed [DW-1:0]     dir2_s10 [3];

	logic [RW-1:0]            rat1, rat2;
	logic [6*DW-1:0]          dir_pk, dir_d;
	logic signed [DW-1:0]     dir_s75 [2][3];
	logic [3*W+2:0]           bse_pk, bse_d;
	logic signed [W-1:0]      base_s78 [3];
	region_t                  reg_s78;
	logic signed [SW-1:0]     sc_s78 [2][3];

	logic signed [SUMW-1:0]   sum_c [3];
	logic signed [W-1:0]      sat_c [3];
	logic signed [W-1:0]      near_s79 [3];
	region_t                  reg_s79;

	// global advance: hold everything while the output word is not taken
	assign en          = !(vld_q[LAT-1] && !result.ready);
	assign query.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], query.valid};
		end
	end

	// unpack the query word
	always_comb begin
		pin[0]    = query.query_x;
		pin[1]    = query.query_y;
		pin[2]    = query.query_z;
		cin[0][0] = query.corner_a_x;
		cin[0][1] = query.corner_a_y;
		cin[0][2] = query.corner_a_z;
		cin[1][0] = query.corner_b_x;
		cin[1][1] = query.corner_b_y;
		cin[1][2] = query.corner_b_z;
		cin[2][0] = query.corner_c_x;
		cin[2][1] = query.corner_c_y;
		cin[2][2] = query.corner_c_z;
		for (int c = 0; c < 3; c++) begin
			for (int k = 0; k < 3; k++) begin
				crn_in[(c*3+k)*W +: W] = cin[c][k];
			end
		end
	end

	// corners ride along until region select
	cpt_dly #(.WIDTH(9*W), .DEPTH(CRN_DLY)) u_crn_dly (
		.clk(clk), .en(en), .d(crn_in), .q(crn_d)
	);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int k = 0; k < 3; k++) begin
				crn_s9[c][k] = crn_d[(c*3+k)*W +: W];
			end
		end
	end

	// s1: edge vectors ab, ac and offsets ap, bp, cp
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				u_s1[0][k] <= DW'(cin[1][k]) - DW'(cin[0][k]);
				u_s1[1][k] <= DW'(cin[2][k]) - DW'(cin[0][k]);
				for (int j = 0; j < 3; j++) begin
					v_s1[j][k] <= DW'(pin[k]) - DW'(cin[j][k]);
				end
			end
		end
	end

	// s2..s4: per-axis products of d1..d6
	for (genvar m = 0; m < 6; m++) begin : g_dot
		for (genvar k = 0; k < 3; k++) begin : g_ax
			cpt_mul #(.AW(DW), .BW(DW)) u_mul (
				.clk(clk), .en(en),
				.a(u_s1[m % 2][k]), .b(v_s1[m / 2][k]), .p(dp_s4[m][k])
			);
		end
	end

	// s5: dot products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < 6; m++) begin
				dot_s5[m] <= DOTW'(dp_s4[m][0]) + DOTW'(dp_s4[m][1]) + DOTW'(dp_s4[m][2]);
			end
		end
	end

	// s6..s8: cross terms, with the dots delayed alongside
	for (genvar i = 0; i < 6; i++) begin : g_cross
		cpt_mul #(.AW(DOTW), .BW(DOTW)) u_mul (
			.clk(clk), .en(en),
			.a(dot_s5[XL[i]]), .b(dot_s5[XR[i]]), .p(xp_s8[i])
		);
	end

	always_comb begin
		for (int m = 0; m < 6; m++) begin
			dot_pk[m*DOTW +: DOTW] = dot_s5[m];
			dot_s8[m]              = dot_d[m*DOTW +: DOTW];
		end
	end

	cpt_dly #(.WIDTH(6*DOTW), .DEPTH(MUL_LAT)) u_dot_dly (
		.clk(clk), .en(en), .d(dot_pk), .q(dot_d)
	);

	// s9: barycentric numerators vc, vb, va and the bc edge terms
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				cr_s9[i] <= XW'(xp_s8[2*i]) - XW'(xp_s8[2*i+1]);
			end
			dot_s9 <= dot_s8;
			t_s9   <= EW'(dot_s8[3]) - EW'(dot_s8[2]);
			u_s9   <= EW'(dot_s8[4]) - EW'(dot_s8[5]);
		end
	end

	// region tests in priority order; unused ratios get a zero numerator
	always_comb begin
		reg_c  = REG_FACE;
		num1_c = NW'(cr_s9[1]);
		num2_c = NW'(cr_s9[0]);
		den_c  = NW'(cr_s9[2]) + NW'(cr_s9[1]) + NW'(cr_s9[0]);
		if (dot_s9[0] <= 0 && dot_s9[1] <= 0) begin
			reg_c  = REG_VTX_A;
			num1_c = '0;
			num2_c = '0;
			den_c  = '0;
		end else if (dot_s9[2] >= 0 && dot_s9[3] <= dot_s9[2]) begin
			reg_c  = REG_VTX_B;
			num1_c = '0;
			num2_c = '0;
			den_c  = '0;
		end else if (cr_s9[0] <= 0 && dot_s9[0] >= 0 && dot_s9[2] <= 0) begin
			reg_c  = REG_EDGE_AB;
			num1_c = NW'(dot_s9[0]);
			num2_c = '0;
			den_c  = NW'(dot_s9[0]) - NW'(dot_s9[2]);
		end else if (dot_s9[5] >= 0 && dot_s9[4] <= dot_s9[5]) begin
			reg_c  = REG_VTX_C;
			num1_c = '0;
			num2_c = '0;
			den_c  = '0;
		end else if (cr_s9[1] <= 0 && dot_s9[1] >= 0 && dot_s9[5] <= 0) begin
			reg_c  = REG_EDGE_AC;
			num1_c = NW'(dot_s9[1]);
			num2_c = '0;
			den_c  = NW'(dot_s9[1]) - NW'(dot_s9[5]);
		end else if (cr_s9[2] <= 0 && t_s9 >= 0 && u_s9 >= 0) begin
			reg_c  = REG_EDGE_BC;
			num1_c = NW'(t_s9);
			num2_c = '0;
			den_c  = NW'(t_s9) + NW'(u_s9);
		end
	end

	// start point and edge directions for the chosen region
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dir2_c[k] = DW'(crn_s9[2][k]) - DW'(crn_s9[0][k]);
			unique case (reg_c)
				REG_VTX_B: begin
					base_c[k] = crn_s9[1][k];
					dir1_c[k] = DW'(crn_s9[1][k]) - DW'(crn_s9[0][k]);
				end
				REG_VTX_C: begin
					base_c[k] = crn_s9[2][k];
					dir1_c[k] = DW'(crn_s9[1][k]) - DW'(crn_s9[0][k]);
				end
				REG_EDGE_AC: begin
					base_c[k] = crn_s9[0][k];
					dir1_c[k] = DW'(crn_s9[2][k]) - DW'(crn_s9[0][k]);
				end
				REG_EDGE_BC: begin
					base_c[k] = crn_s9[1][k];
					dir1_c[k] = DW'(crn_s9[2][k]) - DW'(crn_s9[1][k]);
				end
				default: begin
					base_c[k] = crn_s9[0][k];
					dir1_c[k] = DW'(crn_s9[1][k]) - DW'(crn_s9[0][k]);
				end
			endcase
		end
	end

	// s10: region select register
	always_ff @(posedge clk) begin
		if (en) begin
			reg_s10  <= reg_c;
			num1_s10 <= num1_c;
			num2_s10 <= num2_c;
			den_s10  <= den_c;
			base_s10 <= base_c;
			dir1_s10 <= dir1_c;
			dir2_s10 <= dir2_c;
		end
	end

	// ratio dividers, one per barycentric weight
	cpt_div #(.NW(NW)) u_div1 (
		.clk(clk), .en(en), .num(num1_s10), .den(den_s10), .ratio(rat1)
	);
	cpt_div #(.NW(NW)) u_div2 (
		.clk(clk), .en(en), .num(num2_s10), .den(den_s10), .ratio(rat2)
	);

	// directions wait for the ratios, base and region for the products
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dir_pk[k*DW +: DW]     = dir1_s10[k];
			dir_pk[(3+k)*DW +: DW] = dir2_s10[k];
			dir_s75[0][k]          = dir_d[k*DW +: DW];
			dir_s75[1][k]          = dir_d[(3+k)*DW +: DW];
			bse_pk[k*W +: W]       = base_s10[k];
			base_s78[k]            = bse_d[k*W +: W];
		end
		bse_pk[3*W +: 3] = 3'(reg_s10);
		reg_s78          = region_t'(bse_d[3*W +: 3]);
	end

	cpt_dly #(.WIDTH(6*DW), .DEPTH(DIV_LAT)) u_dir_dly (
		.clk(clk), .en(en), .d(dir_pk), .q(dir_d)
	);

	cpt_dly #(.WIDTH(3*W+3), .DEPTH(DIV_LAT+MUL_LAT)) u_bse_dly (
		.clk(clk), .en(en), .d(bse_pk), .q(bse_d)
	);

	// ratio times direction, per weight and axis
	for (genvar k = 0; k < 3; k++) begin : g_scale
		cpt_mul #(.AW(RW+1), .BW(DW)) u_mul1 (
			.clk(clk), .en(en),
			.a($signed({1'b0, rat1})), .b(dir_s75[0][k]), .p(sc_s78[0][k])
		);
		cpt_mul #(.AW(RW+1), .BW(DW)) u_mul2 (
			.clk(clk), .en(en),
			.a($signed({1'b0, rat2})), .b(dir_s75[1][k]), .p(sc_s78[1][k])
		);
	end

	// floor-scaled terms added to the base, then saturated
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			sum_c[k] = SUMW'(base_s78[k])
				+ SUMW'($signed(sc_s78[0][k][SW-1:FRAC_BITS]))
				+ SUMW'($signed(sc_s78[1][k][SW-1:FRAC_BITS]));
			if (sum_c[k][SUMW-1:W-1] != {(SUMW-W+1){sum_c[k][SUMW-1]}}) begin
				sat_c[k] = sum_c[k][SUMW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			end else begin
				sat_c[k] = sum_c[k][W-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (en) begin
			near_s79 <= sat_c;
			reg_s79  <= reg_s78;
		end
	end

	assign result.valid     = vld_q[LAT-1];
	assign result.nearest_x = near_s79[0];
	assign result.nearest_y = near_s79[1];
	assign result.nearest_z = near_s79[2];
	assign result.region    = reg_s79;

	// a stalled pipeline keeps its occupancy
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline occupancy changed during stall");

	// an accepted word occupies the first stage next cycle
	a_accept_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(query.valid && query.ready) |=> vld_q[0])
		else $error("accepted word missing from first stage");

	// a ratio of one has no fractional bits
	a_ratio_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[RAT_STG-1] && rat1[FRAC_BITS]) |-> (rat1[FRAC_BITS-1:0] == '0))
		else $error("ratio above one");
endmodule

[bench/tb_closest_point_on_triangle_top.sv]
// Testbench for closest_point_on_triangle_top: directed and random queries checked
// against a wide-integer predictor of the Voronoi-region closest point.
// Depends on cpt_pkg, cpt_query_if, cpt_result_if and the top-level RTL.
`timescale 1ns / 1ps

module tb_closest_point_on_triangle_top
	import cpt_pkg::*;
();

	localparam int CB       = 32;
	localparam int S        = 65536;
	localparam int LIMIT    = 400000;
	localparam int TAIL     = 200;
	localparam int PHASE_N  = 272;

	typedef logic signed [CB-1:0]  coord_t;
	typedef logic signed [383:0]   wide_t;

	typedef struct {
		coord_t v[12];          // p, a, b, c; x y z each
	} query_t;

	typedef struct {
		coord_t  x, y, z;
		region_t region;
	} nearest_t;

	typedef struct {
		query_t   q;
		bit       known;
		nearest_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   cycles = 0;
	int   errors = 0;
	int   idle_pct = 0;
	int   stall_pct = 0;

	nearest_t expected_q[$];
	row_t     rows[$];

	cpt_query_if  #(.COORD_BITS(CB)) query_ch();
	cpt_result_if #(.COORD_BITS(CB)) result_ch();

	closest_point_on_triangle_top #(.COORD_BITS(CB)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query_ch),
		.result (result_ch)
	);

	always #1 clk = ~clk;

	// cycle budget
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic wide_t dot3(input wide_t u[3], input wide_t w[3]);
		return u[0] * w[0] + u[1] * w[1] + u[2] * w[2];
	endfunction

	// unsigned fraction num/den with 64 fractional bits, clamped to 0..1
	function automatic wide_t frac(input wide_t num, input wide_t den);
		if (den <= 0 || num <= 0)
			return 0;
		if (den <= num)
			return wide_t'(1) <<< FRAC_BITS;
		return (num <<< FRAC_BITS) / den;
	endfunction

	function automatic coord_t sat(input wide_t r);
		wide_t lo, hi;
		lo = -(wide_t'(1) <<< (CB - 1));
		hi = (wide_t'(1) <<< (CB - 1)) - 1;
		if (r < lo) return coord_t'(lo);
		if (r > hi) return coord_t'(hi);
		return coord_t'(r);
	endfunction

	// closest point on triangle abc to p
	function automatic nearest_t nearest_point(input query_t q);
		wide_t p[3], a[3], b[3], c[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
		wide_t base[3], dir1[3];
		wide_t d1, d2, d3, d4, d5, d6, va, vb, vc, t, u, f1, f2, r;
		region_t rgn;
		nearest_t res;
		for (int k = 0; k < 3; k++) begin
			p[k] = q.v[k];
			a[k] = q.v[3 + k];
			b[k] = q.v[6 + k];
			c[k] = q.v[9 + k];
			ab[k] = b[k] - a[k];
			ac[k] = c[k] - a[k];
			bc[k] = c[k] - b[k];
			ap[k] = p[k] - a[k];
			bp[k] = p[k] - b[k];
			cp[k] = p[k] - c[k];
		end
		d1 = dot3(ab, ap); d2 = dot3(ac, ap);
		d3 = dot3(ab, bp); d4 = dot3(ac, bp);
		d5 = dot3(ab, cp); d6 = dot3(ac, cp);
		vc = d1 * d4 - d3 * d2;
		vb = d5 * d2 - d1 * d6;
		va = d3 * d6 - d5 * d4;
		f1 = 0;
		f2 = 0;
		base = a;
		dir1 = ab;
		if (d1 <= 0 && d2 <= 0) begin
			rgn = REG_VTX_A;
		end else if (d3 >= 0 && d4 <= d3) begin
			rgn = REG_VTX_B; base = b;
		end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
			rgn = REG_EDGE_AB;
			f1 = frac(d1, d1 - d3);
		end else if (d6 >= 0 && d5 <= d6) begin
			rgn = REG_VTX_C; base = c;
		end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
			rgn = REG_EDGE_AC; dir1 = ac;
			f1 = frac(d2, d2 - d6);
		end else begin
			t = d4 - d3;
			u = d5 - d6;
			if (va <= 0 && t >= 0 && u >= 0) begin
				rgn = REG_EDGE_BC; base = b; dir1 = bc;
				f1 = frac(t, t + u);
			end else begin
				rgn = REG_FACE;
				f1 = frac(vb, va + vb + vc);
				f2 = frac(vc, va + vb + vc);
			end
		end
		for (int k = 0; k < 3; k++) begin
			r = base[k] + ((f1 * dir1[k]) >>> FRAC_BITS);
			if (rgn == REG_FACE)
				r = r + ((f2 * ac[k]) >>> FRAC_BITS);
			case (k)
				0: res.x = sat(r);
				1: res.y = sat(r);
				default: res.z = sat(r);
			endcase
		end
		res.region = rgn;
		return res;
	endfunction

	function automatic query_t mk(input coord_t p0, p1, p2, a0, a1, a2,
			b0, b1, b2, c0, c1, c2);
		query_t q;
		q.v = '{p0, p1, p2, a0, a1, a2, b0, b1, b2, c0, c1, c2};
		return q;
	endfunction

	task automatic add_row(input query_t q, input bit known,
			input coord_t x = 0, coord_t y = 0, coord_t z = 0,
			region_t rgn = REG_VTX_A);
		row_t r;
		r.q = q;
		r.known = known;
		r.res = '{x, y, z, rgn};
		rows.push_back(r);
	endtask

	// random query: mostly sensible triangles near the query, some noise
	function automatic query_t rand_query();
		query_t q;
		int kind, span;
		kind = $urandom_range(0, 99);
		span = ($urandom_range(0, 3) == 0) ? (1 << 30) : (1 << 22);
		for (int i = 0; i < 12; i++)
			q.v[i] = (kind < 20) ? coord_t'($urandom)
				: coord_t'(int'($urandom_range(0, 2 * span)) - span);
		if (kind >= 80 && kind < 86)
			for (int k = 0; k < 3; k++) q.v[6 + k] = q.v[3 + k];       // b on a
		else if (kind >= 86 && kind < 92)
			for (int k = 0; k < 3; k++) q.v[9 + k] = q.v[6 + k];       // c on b
		else if (kind >= 92 && kind < 96)
			for (int k = 0; k < 3; k++)                                 // collinear
				q.v[9 + k] = q.v[3 + k] + 2 * (q.v[6 + k] - q.v[3 + k]);
		else if (kind >= 96)
			for (int k = 0; k < 3; k++)                                 // p on a corner
				q.v[k] = q.v[3 * $urandom_range(1, 3) + k];
		return q;
	endfunction

	// drive one word and hold it until it is taken
	task automatic send_word(input query_t q, input bit known, input nearest_t res);
		while ($urandom_range(0, 99) < idle_pct) begin
			query_ch.valid <= 1'b0;
			@(posedge clk);
		end
		query_ch.valid      <= 1'b1;
		query_ch.query_x    <= q.v[0];
		query_ch.query_y    <= q.v[1];
		query_ch.query_z    <= q.v[2];
		query_ch.corner_a_x <= q.v[3];
		query_ch.corner_a_y <= q.v[4];
		query_ch.corner_a_z <= q.v[5];
		query_ch.corner_b_x <= q.v[6];
		query_ch.corner_b_y <= q.v[7];
		query_ch.corner_b_z <= q.v[8];
		query_ch.corner_c_x <= q.v[9];
		query_ch.corner_c_y <= q.v[10];
		query_ch.corner_c_z <= q.v[11];
		do @(posedge clk); while (!query_ch.ready);
		expected_q.push_back(known ? res : nearest_point(q));
	endtask

	// result side: check each word, then pick the next ready
	always @(posedge clk) begin
		nearest_t e;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_q.size() == 0) begin
				$error("result word with nothing expected");
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (result_ch.nearest_x !== e.x) begin
					$error("nearest_x expected %0d got %0d", e.x, result_ch.nearest_x);
					errors++;
				end
				if (result_ch.nearest_y !== e.y) begin
					$error("nearest_y expected %0d got %0d", e.y, result_ch.nearest_y);
					errors++;
				end
				if (result_ch.nearest_z !== e.z) begin
					$error("nearest_z expected %0d got %0d", e.z, result_ch.nearest_z);
					errors++;
				end
				if (result_ch.region !== e.region) begin
					$error("region expected %0d got %0d", e.region, result_ch.region);
					errors++;
				end
			end
		end
		result_ch.ready <= arst_n && ($urandom_range(0, 99) >= stall_pct);
	end

	initial begin
		nearest_t none;
		coord_t mx, mn;
		mx = coord_t'(32'h7fff_ffff);
		mn = coord_t'(32'h8000_0000);
		none = '{0, 0, 0, REG_VTX_A};
		query_ch.valid = 1'b0;
		{query_ch.query_x, query_ch.query_y, query_ch.query_z} = '0;
		{query_ch.corner_a_x, query_ch.corner_a_y, query_ch.corner_a_z} = '0;
		{query_ch.corner_b_x, query_ch.corner_b_y, query_ch.corner_b_z} = '0;
		{query_ch.corner_c_x, query_ch.corner_c_y, query_ch.corner_c_z} = '0;
		result_ch.ready = 1'b0;

		// directed rows: regions of a right triangle, degenerate shapes, extremes
		add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0, REG_VTX_A);
		add_row(mk(-S, -S, 0, 0, 0, 0, 4*S, 0, 0, 0, 4*S, 0), 1, 0, 0, 0, REG_VTX_A);
		add_row(mk(6*S, -S, 0, 0, 0, 0, 4*S, 0, 0, 0, 4*S, 0), 1, 4*S, 0, 0, REG_VTX_B);
		add_row(mk(2*S, -S, S, 0, 0, 0, 4*S, 0, 0, 0, 4*S, 0), 0);
		add_row(mk(-S, 6*S, 0, 0, 0, 0, 4*S, 0, 0, 0, 4*S, 0), 1, 0, 4*S, 0, REG_VTX_C);
		add_row(mk(-S, 2*S, 0, 0, 0, 0, 4*S, 0, 0, 0, 4*S, 0), 0);
		add_row(mk(3*S, 3*S, 0, 0, 0, 0, 4*S, 0, 0, 0, 4*S, 0), 0);
		add_row(mk(S, S, 5*S, 0, 0, 0, 4*S, 0, 0, 0, 4*S, 0), 0);
		add_row(mk(S/3, 7, -5, 0, 0, 0, 3, 0, 0, 0, 3, 0), 0);
		add_row(mk(0, 0, 0, S, S, S, S, S, S, 5*S, S, S), 0);
		add_row(mk(2*S, 3*S, 0, S, S, S, 5*S, S, S, 5*S, S, S), 0);
		add_row(mk(S/2, S, 0, 0, 0, 0, S, 0, 0, 2*S, 0, 0), 0);
		add_row(mk(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx), 1, mx, mx, mx, REG_VTX_A);
		add_row(mk(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn), 1, mn, mn, mn, REG_VTX_A);
		add_row(mk(mx, mx, mx, mn, mn, mn, mx, mn, mx, mn, mx, mn), 0);
		add_row(mk(mn, mn, mn, mx, mx, mx, mn, mx, mn, mx, mn, mx), 0);
		add_row(mk(0, 0, 0, mn, mn, mn, mx, mn, mn, mn, mx, mx), 0);
		add_row(mk(mx, 0, 0, 0, 0, 0, mx, mx, mx, mn, mn, mn), 0);
		add_row(mk(-1, -1, -1, 0, 0, 0, 1, 0, 0, 0, 1, 0), 1, 0, 0, 0, REG_VTX_A);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i])
			send_word(rows[i].q, rows[i].known, rows[i].res);

		// random phases: steady, sender gaps, receiver stalls, both
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = (ph == 1) ? 70 : (ph == 3) ? 24 : 0;
			stall_pct = (ph == 2) ? 70 : (ph == 3) ? 24 : 0;
			for (int n = 0; n < PHASE_N; n++)
				send_word(rand_query(), 0, none);
		end
		query_ch.valid <= 1'b0;

		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (errors == 0 && expected_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule

[sim.f]
rtl/cpt_pkg.sv
rtl/cpt_query_if.sv
rtl/cpt_result_if.sv
rtl/cpt_dly.sv
rtl/cpt_mul.sv
rtl/cpt_div.sv
rtl/closest_point_on_triangle_top.sv
bench/tb_closest_point_on_triangle_top.sv
